/* rtl/msc_pkg.sv */
package msc_pkg;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  load_addr;
    logic [31:0] load_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        reg_write_valid;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        mem_write_valid;
    logic [7:0]  mem_write_addr;
    logic [31:0] mem_write_value;
    logic [2:0]  instr_cycles;
    logic [31:0] total_cycles;
  } out_item_t;

  localparam logic [1:0] StExec   = 2'd0;
  localparam logic [1:0] StHalt   = 2'd1;
  localparam logic [1:0] StUnsup  = 2'd2;
  localparam logic [1:0] StLoad   = 2'd3;

  localparam logic [5:0] OpRtype = 6'd0;
  localparam logic [5:0] OpJ     = 6'd2;
  localparam logic [5:0] OpBeq   = 6'd4;
  localparam logic [5:0] OpLw    = 6'd35;
  localparam logic [5:0] OpSw    = 6'd43;
  localparam logic [5:0] OpHalt  = 6'd63;
  localparam logic [5:0] FnSub   = 6'd34;
  localparam logic [5:0] FnSlt   = 6'd42;

  localparam logic [31:0] GpReset = 32'd100;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    DpNop, DpLoadIn, DpMemWr, DpMemRd, DpIrByte, DpRfRead,
    DpExec, DpLwByte, DpCommit, DpFinish
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] byte_sel;
    logic       use_ea;
  } dp_cmd_t;

  typedef struct packed {
    logic       cmd;
    logic       halted;
    logic [5:0] opcode;
    logic [5:0] funct;
  } dp_stat_t;

endpackage

/* rtl/msc_ram.sv */
module msc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/msc_datapath.sv */
module msc_datapath import msc_pkg::*; #(
  parameter int MemBytes = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_i,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o,
  output out_item_t res_o
);

  localparam int AW = $clog2(MemBytes);

  logic [31:0] rf_q [32];
  logic [31:0] pc_q, total_q, ir_q, a_q, b_q, word_q, ea_q, val_q;
  logic        halted_q, cmd_q;
  logic [AW-1:0] base_q;
  logic [7:0]  laddr_q;
  out_item_t   res_q;

  logic [31:0]   pc_d, total_d;
  logic          halted_d;
  out_item_t     res_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, sel_base;
  logic [7:0]    mem_wdata, mem_rdata;
  logic [31:0]   imm, pc4;
  logic [5:0]    opc, fn;
  logic [4:0]    rs, rt, rd;

  assign opc = ir_q[31:26];
  assign rs  = ir_q[25:21];
  assign rt  = ir_q[20:16];
  assign rd  = ir_q[15:11];
  assign fn  = ir_q[5:0];
  assign imm = {{16{ir_q[15]}}, ir_q[15:0]};
  assign pc4 = pc_q + 32'd4;

  assign sel_base  = cmd_i.use_ea ? ea_q[AW-1:0] : pc_q[AW-1:0];
  assign mem_raddr = sel_base + AW'(cmd_i.byte_sel);
  assign mem_we    = (cmd_i.op == DpMemWr);
  assign mem_waddr = base_q + AW'(cmd_i.byte_sel);

  always_comb begin
    unique case (cmd_i.byte_sel)
      2'd0:    mem_wdata = word_q[31:24];
      2'd1:    mem_wdata = word_q[23:16];
      2'd2:    mem_wdata = word_q[15:8];
      default: mem_wdata = word_q[7:0];
    endcase
  end

  msc_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Outcome of the current item, taken into the state at commit.
  always_comb begin
    res_d        = '0;
    res_d.status = StExec;
    pc_d         = pc_q;
    halted_d     = halted_q;
    if (!cmd_q) begin
      res_d.status = StLoad;
    end else if (halted_q) begin
      res_d.status = StHalt;
    end else begin
      priority case (1'b1)
        opc == OpHalt: begin
          halted_d = 1'b1;
          res_d.status = StHalt;
        end
        opc == OpLw: begin
          pc_d = pc4;
          res_d.instr_cycles = 3'd5;
          if (rt != 5'd0) begin
            res_d.reg_write_valid = 1'b1;
            res_d.reg_write_index = rt;
            res_d.reg_write_value = word_q;
          end
        end
        opc == OpSw: begin
          pc_d = pc4;
          res_d.instr_cycles = 3'd4;
          res_d.mem_write_valid = 1'b1;
          res_d.mem_write_addr = laddr_q;
          res_d.mem_write_value = b_q;
        end
        opc == OpRtype && (fn == FnSub || fn == FnSlt): begin
          pc_d = pc4;
          res_d.instr_cycles = 3'd4;
          if (rd != 5'd0) begin
            res_d.reg_write_valid = 1'b1;
            res_d.reg_write_index = rd;
            res_d.reg_write_value = val_q;
          end
        end
        opc == OpBeq: begin
          pc_d = (a_q == b_q) ? pc4 + {imm[29:0], 2'b00} : pc4;
          res_d.instr_cycles = 3'd3;
        end
        opc == OpJ: begin
          pc_d = {pc4[31:28], ir_q[25:0], 2'b00};
          res_d.instr_cycles = 3'd3;
        end
        default: res_d.status = StUnsup;
      endcase
    end
    total_d = total_q + 32'(res_d.instr_cycles);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) begin
        rf_q[i] <= (i == 28) ? GpReset : 32'd0;
      end
      pc_q     <= '0;
      total_q  <= '0;
      halted_q <= 1'b0;
      res_q    <= '0;
    end else begin
      if (cmd_i.op == DpCommit) begin
        res_q    <= res_d;
        pc_q     <= pc_d;
        total_q  <= total_d;
        halted_q <= halted_d;
        if (res_d.reg_write_valid) begin
          rf_q[res_d.reg_write_index] <= res_d.reg_write_value;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DpLoadIn: begin
        cmd_q   <= in_i.cmd;
        word_q  <= in_i.load_word;
        base_q  <= AW'(in_i.load_addr);
        laddr_q <= in_i.load_addr;
      end
      DpIrByte: ir_q <= {ir_q[23:0], mem_rdata};
      DpRfRead: begin
        a_q <= rf_q[rs];
        b_q <= rf_q[rt];
      end
      DpExec: begin
        ea_q    <= a_q + imm;
        word_q  <= b_q;
        base_q  <= AW'(a_q + imm);
        laddr_q <= 8'(AW'(a_q + imm));
        val_q   <= (fn == FnSub) ? a_q - b_q
                 : {31'd0, $signed(a_q) < $signed(b_q)};
      end
      DpLwByte: word_q <= {word_q[23:0], mem_rdata};
      default: ;
    endcase
  end

  always_comb begin
    res_o = res_q;
    res_o.next_pc = pc_q;
    res_o.total_cycles = total_q;
  end

  assign stat_o.cmd    = cmd_q;
  assign stat_o.halted = halted_q;
  assign stat_o.opcode = opc;
  assign stat_o.funct  = fn;

endmodule

/* rtl/msc_ctrl.sv */
module msc_ctrl import msc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDecide = 4'd1;
  localparam logic [3:0] SStore  = 4'd2;
  localparam logic [3:0] SFetchR = 4'd3;
  localparam logic [3:0] SFetchC = 4'd4;
  localparam logic [3:0] SRfRead = 4'd5;
  localparam logic [3:0] SExec   = 4'd6;
  localparam logic [3:0] SLwR    = 4'd7;
  localparam logic [3:0] SLwC    = 4'd8;
  localparam logic [3:0] SCommit = 4'd9;
  localparam logic [3:0] SOut    = 4'd10;

  logic [3:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       accept;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '{op: DpNop, byte_sel: cnt_q[1:0], use_ea: 1'b0};
    unique case (state_q)
      SIdle: if (accept) begin
        cmd_o.op = DpLoadIn;
        state_d = SDecide;
      end
      SDecide: begin
        cnt_d = '0;
        if (!stat_i.cmd) state_d = SStore;
        else if (stat_i.halted) state_d = SCommit;
        else state_d = SFetchR;
      end
      SStore: begin
        cmd_o.op = DpMemWr;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) state_d = SCommit;
      end
      SFetchR: state_d = SFetchC;
      SFetchC: begin
        cmd_o.op = DpIrByte;
        cmd_o.byte_sel = cnt_q[1:0] - 2'd1;
        cnt_d = cnt_q + 3'd1;
        state_d = (cnt_q == 3'd3) ? SRfRead : SFetchR;
      end
      SRfRead: begin
        cmd_o.op = DpRfRead;
        state_d = SExec;
      end
      SExec: begin
        cmd_o.op = DpExec;
        cnt_d = '0;
        if (stat_i.opcode == OpLw) state_d = SLwR;
        else if (stat_i.opcode == OpSw) state_d = SStore;
        else state_d = SCommit;
      end
      SLwR: begin
        cmd_o.use_ea = 1'b1;
        state_d = SLwC;
      end
      SLwC: begin
        cmd_o.op = DpLwByte;
        cnt_d = cnt_q + 3'd1;
        state_d = (cnt_q == 3'd3) ? SCommit : SLwR;
      end
      SCommit: begin
        cmd_o.op = DpCommit;
        state_d = SOut;
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_ready_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid both high");
  a_commit_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SCommit) |=> out_valid_o) else $error("commit not followed by output");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("byte counter out of range");

endmodule

/* rtl/mips_subset_multicycle_core.sv */
// From input transfer to result valid: a preload writes its word byte by byte; an instruction
// is fetched, decoded and executed, then sw stores and lw loads bytes; while halted, commit follows.
// Fetch and lw bytes each take a read state followed by a capture state; stores write one byte a cycle.
// Throughput: one item at a time; input is ready in the cycle after the result transfer.
// Reset (rst_ni low, asynchronous): PC, cycle total and halt flag clear, registers clear
// except register 28 = 100; memory contents are undefined until written.
module mips_subset_multicycle_core import msc_pkg::*; #(
  parameter int MEM_BYTES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  msc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  msc_datapath #(.MemBytes(MEM_BYTES)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_data_i),
    .cmd_i  (dp_cmd),
    .stat_o (dp_stat),
    .res_o  (out_data_o)
  );

endmodule
